// ----- design/nsf_pkg.sv -----
// Shared types, character codes and decode functions for the NMEA sentence framer.
// Used by nsf_framer and nmea_sentence_framer_core; no dependencies.
package nsf_pkg;

   // Default cap on the buffered sentence size (bytes kept = NSF_MAX_LEN - 1).
   localparam int NSF_MAX_LEN = 128;

   localparam logic [7:0] NSF_CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] NSF_CHAR_STAR   = 8'h2A;
   localparam logic [7:0] NSF_CHAR_LF     = 8'h0A;
   localparam logic [7:0] NSF_CHAR_CR     = 8'h0D;
   localparam logic [7:0] NSF_CHAR_0      = 8'h30;
   localparam logic [7:0] NSF_CHAR_9      = 8'h39;
   localparam logic [7:0] NSF_CHAR_UA     = 8'h41;
   localparam logic [7:0] NSF_CHAR_UF     = 8'h46;
   localparam logic [7:0] NSF_CHAR_LA     = 8'h61;
   localparam logic [7:0] NSF_CHAR_LF_HEX = 8'h66;
   localparam logic [7:0] NSF_CHAR_G      = 8'h47;
   localparam logic [7:0] NSF_CHAR_R      = 8'h52;
   localparam logic [7:0] NSF_CHAR_M      = 8'h4D;
   localparam logic [7:0] NSF_CHAR_C      = 8'h43;
   localparam logic [7:0] NSF_CHAR_S      = 8'h53;
   localparam logic [7:0] NSF_CHAR_V      = 8'h56;
   localparam logic [7:0] NSF_CHAR_T      = 8'h54;

   // Offset from a letter to its hex value ('A' - 10 and 'a' - 10).
   localparam logic [7:0] NSF_UPPER_OFS = 8'h37;
   localparam logic [7:0] NSF_LOWER_OFS = 8'h57;

   // Sentence id of the smallest length that can be classified ($ + 5 chars).
   localparam int NSF_MIN_ID_LEN = 6;

   typedef enum logic [2:0] {
      NSF_UNKNOWN = 3'd0,
      NSF_GGA     = 3'd1,
      NSF_RMC     = 3'd2,
      NSF_GSV     = 3'd3,
      NSF_GSA     = 3'd4,
      NSF_VTG     = 3'd5
   } nsf_stype_type;

   // Result of one processed byte, before the output register.
   typedef struct packed {
      logic          emit;
      nsf_stype_type stype;
      logic          ok;
   } nsf_result_type;

   // Return {valid, value} for one ASCII hex digit.
   function automatic logic [4:0] nsf_hex_digit(input logic [7:0] c);
      logic [7:0] d;
      logic       v;
      d = 8'h00;
      v = 1'b0;
      if (c >= NSF_CHAR_0 && c <= NSF_CHAR_9) begin
         d = c - NSF_CHAR_0;
         v = 1'b1;
      end else if (c >= NSF_CHAR_UA && c <= NSF_CHAR_UF) begin
         d = c - NSF_UPPER_OFS;
         v = 1'b1;
      end else if (c >= NSF_CHAR_LA && c <= NSF_CHAR_LF_HEX) begin
         d = c - NSF_LOWER_OFS;
         v = 1'b1;
      end
      return {v, d[3:0]};
   endfunction

   // Parse up to two hex digits from the left; stop at the first non-hex byte.
   function automatic logic [7:0] nsf_parse_hex(input logic [7:0] h0, input logic [7:0] h1);
      logic [4:0] d0;
      logic [4:0] d1;
      logic [7:0] v;
      d0 = nsf_hex_digit(h0);
      d1 = nsf_hex_digit(h1);
      v  = 8'h00;
      if (d0[4]) begin
         if (d1[4]) v = {d0[3:0], d1[3:0]};
         else       v = {4'h0, d0[3:0]};
      end
      return v;
   endfunction

   function automatic nsf_stype_type nsf_classify(input logic [7:0] a, input logic [7:0] b,
                                                  input logic [7:0] c);
      nsf_stype_type t;
      t = NSF_UNKNOWN;
      if (a == NSF_CHAR_G && b == NSF_CHAR_G && c == NSF_CHAR_UA)      t = NSF_GGA;
      else if (a == NSF_CHAR_R && b == NSF_CHAR_M && c == NSF_CHAR_C) t = NSF_RMC;
      else if (a == NSF_CHAR_G && b == NSF_CHAR_S && c == NSF_CHAR_V) t = NSF_GSV;
      else if (a == NSF_CHAR_G && b == NSF_CHAR_S && c == NSF_CHAR_UA) t = NSF_GSA;
      else if (a == NSF_CHAR_V && b == NSF_CHAR_T && c == NSF_CHAR_G) t = NSF_VTG;
      return t;
   endfunction

endpackage

// ----- design/nmea_sentence_framer_core.sv -----
// Top level of the NMEA 0183 sentence framer and checksum checker.
// Depends on nsf_pkg and nsf_framer.
//
// Usage:
//   req_* carries one received character per item (req_rx_byte). An item is
//   taken at a rising edge with req_valid high and req_stall low.
//   rsp_* carries one result item per line feed that ends a sentence:
//   rsp_sentence_type (0 unknown, 1 GGA, 2 RMC, 3 GSV, 4 GSA, 5 VTG),
//   rsp_sum_match and rsp_sentence_length (dollar to line feed, capped at
//   MAX_LEN - 1, low 7 bits). Bytes outside a sentence produce no item.
// Timing: an item is taken into the input register and then processed by
//   the framer; its result, if any, enters the result register at the edge
//   that processes it and shows on rsp_* right after that edge.
// Throughput: one byte per cycle while rsp_stall is low, set by the
//   single input register feeding the per-byte framer and result register.
// Reset: synchronous, active high; the framer returns to hunting for a
//   dollar and both registers empty. No clearing pass is needed.
// Stall: while a result waits under rsp_stall the framer halts; the input
//   register takes at most one more item and then raises req_stall until
//   the result drains.
module nmea_sentence_framer_core #(
   parameter int MAX_LEN = nsf_pkg::NSF_MAX_LEN
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_sentence_type,
   output logic       rsp_sum_match,
   output logic [6:0] rsp_sentence_length
);
   import nsf_pkg::*;

   localparam int PW = $clog2(MAX_LEN);
   localparam int LW = PW + 1;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // result register
   logic       rsp_valid_ff;
   logic [2:0] rsp_type_ff;
   logic       rsp_ok_ff;
   logic [6:0] rsp_len_ff;

   logic           out_free;
   logic           proc_go;
   nsf_result_type res;
   logic [LW-1:0]  res_length;
   logic [LW+6:0]  len_wide;

   // The result register can take a new value when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign proc_go   = in_valid_ff && out_free;
   // Hold the held byte only when it cannot advance into the framer.
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   nsf_framer #(
      .MAX_LEN (MAX_LEN),
      .PW      (PW),
      .LW      (LW)
   ) u_framer (
      .clock      (clock),
      .reset      (reset),
      .byte_go    (proc_go),
      .byte_val   (in_byte_ff),
      .res        (res),
      .res_length (res_length)
   );

   // Zero-extend before taking the low 7 bits so any MAX_LEN fits.
   assign len_wide = {7'b0, res_length};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= proc_go && res.emit;
      end
   end

   // Load the payload only with a fresh result; a stalled result holds.
   always_ff @(posedge clock) begin
      if (out_free && proc_go && res.emit) begin
         rsp_type_ff <= res.stype;
         rsp_ok_ff   <= res.ok;
         rsp_len_ff  <= len_wide[6:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sentence_type   = rsp_type_ff;
   assign rsp_sum_match       = rsp_ok_ff;
   assign rsp_sentence_length = rsp_len_ff;

endmodule

// ----- design/nsf_framer.sv -----
// Per-byte sentence state: position, running XOR, star capture, id capture.
// Depends on nsf_pkg; instantiated by nmea_sentence_framer_core.
module nsf_framer #(
   parameter int MAX_LEN = nsf_pkg::NSF_MAX_LEN,
   parameter int PW      = $clog2(MAX_LEN),
   parameter int LW      = PW + 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_go,
   input  logic [7:0]              byte_val,
   output nsf_pkg::nsf_result_type res,
   output logic [LW-1:0]           res_length
);
   import nsf_pkg::*;

   localparam logic [LW-1:0] CAP = LW'(MAX_LEN - 1);

   logic          in_sentence_ff, in_sentence_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    xor_ff, xor_in;
   logic          stopped_ff, stopped_in;
   logic          star_seen_ff, star_seen_in;
   logic [PW-1:0] star_pos_ff, star_pos_in;
   logic [7:0]    hex_ff [2];
   logic [7:0]    hex_in [2];
   logic [7:0]    id_ff [3];
   logic [7:0]    id_in [3];

   logic [LW-1:0] pos_w, star_w, len_raw, len_cap;
   logic          kept, is_lf, is_term;

   always_comb begin
      pos_w   = {1'b0, pos_ff};
      star_w  = {1'b0, star_pos_ff};
      kept    = in_sentence_ff && (pos_w < CAP);
      is_lf   = (byte_val == NSF_CHAR_LF);
      is_term = (byte_val == NSF_CHAR_STAR) || (byte_val == NSF_CHAR_CR) || is_lf;

      in_sentence_in = in_sentence_ff;
      pos_in         = pos_ff;
      xor_in         = xor_ff;
      stopped_in     = stopped_ff;
      star_seen_in   = star_seen_ff;
      star_pos_in    = star_pos_ff;
      hex_in         = hex_ff;
      id_in          = id_ff;

      if (!in_sentence_ff) begin
         // hunt for the opening dollar
         if (byte_val == NSF_CHAR_DOLLAR) begin
            in_sentence_in = 1'b1;
            pos_in         = PW'(1);
            xor_in         = 8'h00;
            stopped_in     = 1'b0;
            star_seen_in   = 1'b0;
            star_pos_in    = '0;
         end
      end else begin
         if (kept) begin
            if (!stopped_ff) begin
               if (is_term) stopped_in = 1'b1;
               else         xor_in     = xor_ff ^ byte_val;
            end
            if (star_seen_ff) begin
               if (pos_w == star_w + LW'(1))      hex_in[0] = byte_val;
               else if (pos_w == star_w + LW'(2)) hex_in[1] = byte_val;
            end else if (byte_val == NSF_CHAR_STAR) begin
               star_seen_in = 1'b1;
               star_pos_in  = pos_ff;
            end
            if (pos_w == LW'(3)) id_in[0] = byte_val;
            if (pos_w == LW'(4)) id_in[1] = byte_val;
            if (pos_w == LW'(5)) id_in[2] = byte_val;
            pos_in = pos_ff + PW'(1);
         end
         if (is_lf) in_sentence_in = 1'b0;
      end

      len_raw    = pos_w + LW'(1);
      len_cap    = (len_raw > CAP) ? CAP : len_raw;
      res_length = len_cap;
      res.emit   = byte_go && in_sentence_ff && is_lf;
      res.ok     = star_seen_ff && ((star_w + LW'(2)) < len_cap) &&
                   (nsf_parse_hex(hex_in[0], hex_in[1]) == xor_ff);
      res.stype  = (len_cap >= LW'(NSF_MIN_ID_LEN)) ?
                   nsf_classify(id_in[0], id_in[1], id_in[2]) : NSF_UNKNOWN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         pos_ff         <= '0;
         xor_ff         <= 8'h00;
         stopped_ff     <= 1'b0;
         star_seen_ff   <= 1'b0;
         star_pos_ff    <= '0;
      end else if (byte_go) begin
         in_sentence_ff <= in_sentence_in;
         pos_ff         <= pos_in;
         xor_ff         <= xor_in;
         stopped_ff     <= stopped_in;
         star_seen_ff   <= star_seen_in;
         star_pos_ff    <= star_pos_in;
      end
   end

   // capture stores: read only after being written in the current sentence
   always_ff @(posedge clock) begin
      if (byte_go) begin
         hex_ff <= hex_in;
         id_ff  <= id_in;
      end
   end

`ifndef SYNTHESIS
   a_ok_needs_star_and_digits: assert property (@(posedge clock) disable iff (reset)
      res.emit && res.ok |-> res_length >= LW'(4))
      else $error("sum match on a sentence too short to hold a star and two digits");

   a_type_needs_id: assert property (@(posedge clock) disable iff (reset)
      res.emit && (res.stype != NSF_UNKNOWN) |-> res_length >= LW'(NSF_MIN_ID_LEN))
      else $error("sentence type decoded on a sentence shorter than its id");

   a_lf_closes: assert property (@(posedge clock) disable iff (reset)
      res.emit |=> !in_sentence_ff)
      else $error("line feed did not close the sentence");

   a_open_at_one: assert property (@(posedge clock) disable iff (reset)
      $rose(in_sentence_ff) |-> pos_ff == PW'(1) && !star_seen_ff && !stopped_ff)
      else $error("sentence opened with stale position or flags");
`endif

endmodule
